// ===== hw/rtl/int8_layer_norm_top_assert.svh =====
// Assertion macros shared by the layer normalisation top level.
`ifndef INT8_LAYER_NORM_TOP_ASSERT_SVH
`define INT8_LAYER_NORM_TOP_ASSERT_SVH

// Antecedent holds, so the consequent holds in the same cycle.
`define ILN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds, so the consequent holds in the next cycle.
`define ILN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/iln_pkg.sv =====
`default_nettype none
package iln_pkg;

    // Token buffer geometry.
    localparam int MAX_DIM = 64;
    localparam int ADDR_W  = $clog2(MAX_DIM);
    localparam int CNT_W   = $clog2(MAX_DIM + 1);

    // Iteration counts of the shared root and divide units.
    localparam int SQRT_STEPS = 17;
    localparam int DIV_STEPS  = 32;

    // Configuration register indexes.
    localparam logic [2:0] CFG_TOKEN_LENGTH = 3'd0;
    localparam logic [2:0] CFG_IN_FRAC      = 3'd1;
    localparam logic [2:0] CFG_EPSILON      = 3'd2;
    localparam logic [2:0] CFG_RECIP_FRAC   = 3'd3;
    localparam logic [2:0] CFG_OUT_FRAC     = 3'd4;

    // Output saturation limits.
    localparam int OUT_HI = 127;
    localparam int OUT_LO = -128;

    typedef struct packed {
        logic signed [7:0] x_value;
        logic signed [7:0] gamma_value;
        logic signed [7:0] beta_value;
    } in_beat_t;

    typedef struct packed {
        logic signed [7:0] y_value;
        logic              last_element;
    } out_beat_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic var_mul;
        logic var_sub;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic rd;
        logic mul1;
        logic mul2;
        logic mul3;
        logic sum;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic token_end;
        logic last_elem;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/iln_ctrl.sv =====
`default_nettype none
module iln_ctrl (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  iln_pkg::sts_t    sts,
    output iln_pkg::cmd_t    cmd
);

    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_VMUL  = 4'd1;
    localparam logic [3:0] ST_VSUB  = 4'd2;
    localparam logic [3:0] ST_SQRT  = 4'd3;
    localparam logic [3:0] ST_DINIT = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_RD    = 4'd6;
    localparam logic [3:0] ST_MUL1  = 4'd7;
    localparam logic [3:0] ST_MUL2  = 4'd8;
    localparam logic [3:0] ST_MUL3  = 4'd9;
    localparam logic [3:0] ST_SUM   = 4'd10;
    localparam logic [3:0] ST_EMIT  = 4'd11;

    localparam int IT_W = $clog2(iln_pkg::DIV_STEPS);

    logic [3:0]      state_reg, state_next;
    logic [IT_W-1:0] iter_reg, iter_next;

    assign s_ready = (state_reg == ST_LOAD);

    // Next state, iteration count and datapath commands.
    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (sts.token_end) begin
                        state_next = ST_VMUL;
                    end
                end
            end
            ST_VMUL: begin
                cmd.var_mul = 1'b1;
                state_next  = ST_VSUB;
            end
            ST_VSUB: begin
                cmd.var_sub = 1'b1;
                iter_next   = IT_W'(iln_pkg::SQRT_STEPS - 1);
                state_next  = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                iter_next     = iter_reg - 1'b1;
                if (iter_reg == '0) begin
                    state_next = ST_DINIT;
                end
            end
            ST_DINIT: begin
                cmd.div_init = 1'b1;
                iter_next    = IT_W'(iln_pkg::DIV_STEPS - 1);
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg - 1'b1;
                if (iter_reg == '0) begin
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                cmd.rd     = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_MUL3;
            end
            ST_MUL3: begin
                cmd.mul3   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = sts.last_elem ? ST_LOAD : ST_RD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/iln_dp.sv =====
`default_nettype none
module iln_dp (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  iln_pkg::cmd_t      cmd,
    output iln_pkg::sts_t      sts,
    input  iln_pkg::in_beat_t  s_data,
    input  wire logic          cfg_valid,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [31:0]   cfg_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output iln_pkg::out_beat_t m_data
);

    localparam int AW = iln_pkg::ADDR_W;
    localparam int CW = iln_pkg::CNT_W;

    // Configuration registers.
    logic [6:0]  tlen_reg;
    logic [3:0]  ifb_reg;
    logic [31:0] eps_reg;
    logic [4:0]  rfb_reg;
    logic [3:0]  ofb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tlen_reg <= 7'd64;
            ifb_reg  <= 4'd7;
            eps_reg  <= 32'd671;
            rfb_reg  <= 5'd24;
            ofb_reg  <= 4'd7;
        end else if (cfg_valid) begin
            case (cfg_index)
                iln_pkg::CFG_TOKEN_LENGTH: tlen_reg <= cfg_data[6:0];
                iln_pkg::CFG_IN_FRAC:      ifb_reg  <= cfg_data[3:0];
                iln_pkg::CFG_EPSILON:      eps_reg  <= cfg_data;
                iln_pkg::CFG_RECIP_FRAC:   rfb_reg  <= cfg_data[4:0];
                iln_pkg::CFG_OUT_FRAC:     ofb_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Effective token length: zero counts as one, long values saturate.
    logic [CW-1:0] dlen;
    always_comb begin
        if (tlen_reg == '0) begin
            dlen = CW'(1);
        end else if (32'(tlen_reg) > iln_pkg::MAX_DIM) begin
            dlen = CW'(iln_pkg::MAX_DIM);
        end else begin
            dlen = CW'(tlen_reg);
        end
    end

    // Element buffer and running sums.
    logic [23:0]          mem [iln_pkg::MAX_DIM];
    logic [23:0]          rd_reg;
    logic [CW-1:0]        count_reg;
    logic signed [14:0]   sum_reg;
    logic [20:0]          sq_reg;
    logic [AW-1:0]        wr_addr;
    logic [15:0]          x_sq;

    assign wr_addr = (32'(count_reg) >= iln_pkg::MAX_DIM) ? AW'(iln_pkg::MAX_DIM - 1)
                                                          : count_reg[AW-1:0];
    assign x_sq    = 16'($signed({{8{s_data.x_value[7]}}, s_data.x_value})
                         * $signed({{8{s_data.x_value[7]}}, s_data.x_value}));
    assign sts.token_end = ({1'b0, count_reg} + 1'b1) >= {1'b0, dlen};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mem[wr_addr] <= {s_data.x_value, s_data.gamma_value, s_data.beta_value};
        end
    end

    // Token statistics captured when the token closes.
    logic [CW-1:0]       n_reg;
    logic signed [14:0]  s_reg;
    logic [26:0]         nss_reg;
    logic [26:0]         sss_reg;
    logic signed [27:0]  diff;
    logic [26:0]         var_pos;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
        end else if (cmd.load) begin
            count_reg <= CW'(wr_addr) + 1'b1;
            sum_reg   <= sum_reg + 15'(s_data.x_value);
            sq_reg    <= sq_reg + 21'(x_sq);
        end else if (cmd.var_mul) begin
            count_reg <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.var_mul) begin
            n_reg   <= count_reg;
            s_reg   <= sum_reg;
            nss_reg <= 27'(27'(count_reg) * 27'(sq_reg));
            sss_reg <= 27'(30'(sum_reg * sum_reg));
        end
    end

    assign diff    = $signed({1'b0, nss_reg}) - $signed({1'b0, sss_reg});
    assign var_pos = diff[27] ? '0 : diff[26:0];

    // Bit-by-bit square root, one result bit per step.
    logic [33:0] rad_reg;
    logic [18:0] rem_reg;
    logic [16:0] root_reg;
    logic [20:0] rem_sh;
    logic [20:0] trial;

    assign rem_sh = {rem_reg, rad_reg[33:32]};
    assign trial  = {2'b00, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (cmd.var_sub) begin
            rad_reg  <= {7'd0, var_pos} + {2'd0, eps_reg};
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg <= {rad_reg[31:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_reg  <= 19'(rem_sh - trial);
                root_reg <= {root_reg[15:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh[18:0];
                root_reg <= {root_reg[15:0], 1'b0};
            end
        end
    end

    // Restoring divider for the rounded reciprocal, one quotient bit per step.
    logic [16:0] div_d_reg;
    logic [16:0] div_rem_reg;
    logic [31:0] div_q_reg;
    logic [16:0] root_cl;
    logic [17:0] div_sh;
    logic        div_ge;

    assign root_cl = (root_reg == '0) ? 17'd1 : root_reg;
    assign div_sh  = {div_rem_reg, div_q_reg[31]};
    assign div_ge  = div_sh >= {1'b0, div_d_reg};

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            div_d_reg   <= root_cl;
            div_rem_reg <= '0;
            div_q_reg   <= (32'd1 << rfb_reg) + {16'd0, root_cl[16:1]};
        end else if (cmd.div_step) begin
            div_rem_reg <= div_ge ? 17'(div_sh - {1'b0, div_d_reg}) : div_sh[16:0];
            div_q_reg   <= {div_q_reg[30:0], div_ge};
        end
    end

    // Output shift and its rounding constant.
    logic signed [6:0]  sh_full;
    logic [5:0]         sh;
    logic signed [56:0] half;

    assign sh_full = $signed(7'({3'd0, ifb_reg} + {2'd0, rfb_reg} - {3'd0, ofb_reg}));
    assign sh      = sh_full[6] ? 6'd0 : sh_full[5:0];
    assign half    = (sh == '0) ? '0 : (57'sd1 <<< (sh - 1'b1));

    // Per-element arithmetic, one stage per controller step.
    logic [CW-1:0]       el_idx_reg;
    logic signed [15:0]  num_reg;
    logic signed [48:0]  p1_reg;
    logic signed [56:0]  p2_reg;
    logic signed [56:0]  acc_reg;
    logic signed [7:0]   rd_x;
    logic signed [7:0]   rd_g;
    logic signed [7:0]   rd_b;
    logic signed [15:0]  nx;
    logic signed [56:0]  b_ext;
    logic signed [56:0]  shifted;
    logic signed [7:0]   y_sat;

    assign rd_x  = rd_reg[23:16];
    assign rd_g  = rd_reg[15:8];
    assign rd_b  = rd_reg[7:0];
    assign nx    = $signed({8'd0, 1'b0, n_reg}) * $signed({{8{rd_x[7]}}, rd_x});
    assign b_ext = $signed({{49{rd_b[7]}}, rd_b}) <<< rfb_reg;

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rd_reg <= mem[el_idx_reg[AW-1:0]];
        end
        if (cmd.mul1) begin
            num_reg <= nx - 16'(s_reg);
        end
        if (cmd.mul2) begin
            p1_reg <= num_reg * $signed({1'b0, div_q_reg});
        end
        if (cmd.mul3) begin
            p2_reg <= p1_reg * rd_g;
        end
        if (cmd.sum) begin
            acc_reg <= p2_reg + b_ext + half;
        end
    end

    // Arithmetic shift and saturation into the output register.
    assign shifted = acc_reg >>> sh;
    always_comb begin
        if (shifted > 57'sd127) begin
            y_sat = 8'(iln_pkg::OUT_HI);
        end else if (shifted < -57'sd128) begin
            y_sat = 8'(iln_pkg::OUT_LO);
        end else begin
            y_sat = shifted[7:0];
        end
    end

    assign sts.last_elem = (el_idx_reg == n_reg - 1'b1);

    logic m_valid_reg;
    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            el_idx_reg  <= '0;
        end else begin
            if (cmd.var_mul) begin
                el_idx_reg <= '0;
            end else if (cmd.emit) begin
                el_idx_reg <= el_idx_reg + 1'b1;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data.y_value      <= y_sat;
            m_data.last_element <= sts.last_elem;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/int8_layer_norm_top.sv =====
// Loading: one element beat per cycle; the token closes on the beat that fills it.
// After the closing beat: variance multiply and subtract, 17 square-root steps, divider
// init and steps, then per element read, mul1, mul2, mul3, sum and emit.
// Elements go one at a time; emit waits on a held output; input reopens after the last.
// Reset: synchronous, active low; sums, counts, config and handshakes clear, buffer does not.
`default_nettype none
`include "int8_layer_norm_top_assert.svh"
module int8_layer_norm_top (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  iln_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output iln_pkg::out_beat_t m_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);

    iln_pkg::cmd_t cmd;
    iln_pkg::sts_t sts;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    iln_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    iln_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Results are produced only while the input side is closed.
    `ILN_ASSERT_NOW(a_emit_closed, $rose(m_valid), !$past(s_ready), "result while loading")
    // An input beat never raises a result in the next cycle.
    `ILN_ASSERT_NEXT(a_load_no_out, s_valid && s_ready && !m_valid, !m_valid,
                     "result raised by input beat")
    // While a non-final result is held, the token is still being emitted.
    `ILN_ASSERT_NOW(a_mid_token, m_valid && !m_data.last_element, !s_ready,
                    "input opened mid-token")

endmodule
`default_nettype wire
